/* design/fth_pkg.sv */
// fth_pkg: shared types and constants for the folding time histogram
// no dependencies
`default_nettype none
package fth_pkg;
   localparam int TsW    = 48;
   localparam int ValW   = 32;
   localparam int QbW    = 5;
   localparam int SumW   = 56;
   localparam int CntW   = 32;
   localparam int WidW   = 56;
   localparam int CsrAw  = 4;
   localparam int CsrDw  = 64;

   localparam logic [CsrAw-1:0] RegStartTime = 4'd0;
   localparam logic [CsrAw-1:0] RegInitWidth = 4'd8;

   localparam logic OpSample = 1'b0;
   localparam logic OpQuery  = 1'b1;

   localparam logic StatOk    = 1'b0;
   localparam logic StatEarly = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic            op;
      logic            early;
      logic [TsW-1:0]  offset;
      logic [ValW-1:0] value;
      logic [QbW-1:0]  qbin;
   } cmd_type;

   typedef struct packed {
      logic            status;
      logic [QbW-1:0]  bin_index;
      logic [SumW-1:0] bin_sum;
      logic [CntW-1:0] bin_count;
      logic [CntW-1:0] bin_mean;
      logic [WidW-1:0] current_width;
   } rsp_type;
endpackage
`default_nettype wire

/* design/fth_req_if.sv */
// fth_req_if: input item channel (valid/ready with sample or query payload)
// depends on fth_pkg
`default_nettype none
interface fth_req_if import fth_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            op;
   logic [TsW-1:0]  timestamp;
   logic [ValW-1:0] sample_value;
   logic [QbW-1:0]  query_bin;
   modport source (output valid, op, timestamp, sample_value, query_bin, input ready);
   modport sink   (input valid, op, timestamp, sample_value, query_bin, output ready);
endinterface
`default_nettype wire

/* design/fth_rsp_if.sv */
// fth_rsp_if: result channel (valid/ready with bin result payload)
// depends on fth_pkg
`default_nettype none
interface fth_rsp_if import fth_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            status;
   logic [QbW-1:0]  bin_index;
   logic [SumW-1:0] bin_sum;
   logic [CntW-1:0] bin_count;
   logic [CntW-1:0] bin_mean;
   logic [WidW-1:0] current_width;
   modport source (output valid, status, bin_index, bin_sum, bin_count, bin_mean,
                   current_width, input ready);
   modport sink   (input valid, status, bin_index, bin_sum, bin_count, bin_mean,
                   current_width, output ready);
endinterface
`default_nettype wire

/* design/fth_front.sv */
// fth_front: accepts items, checks timestamp against start, forms offset, two-entry queue
// depends on fth_pkg
`default_nettype none
module fth_front import fth_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [TsW-1:0]  start_time,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic            in_op,
   input  wire logic [TsW-1:0]  in_timestamp,
   input  wire logic [ValW-1:0] in_value,
   input  wire logic [QbW-1:0]  in_qbin,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output cmd_type              cmd
);
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_valid && cmd_ready;

   // classify
   always_comb begin
      q_in.op     = in_op;
      q_in.early  = (in_op == OpSample) && (in_timestamp < start_time);
      q_in.offset = in_timestamp - start_time;
      q_in.value  = in_value;
      q_in.qbin   = in_qbin;
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= q_in;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

/* design/fth_back.sv */
// fth_back: bin index division, folding sweep, bin update, mean division, result register
// depends on fth_pkg
`default_nettype none
module fth_back import fth_pkg::*; #(
   parameter int NUM_BINS = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            width_load,
   input  wire logic [TsW-1:0]  width_value,
   input  wire logic            cmd_valid,
   output logic                 cmd_ready,
   input  cmd_type              cmd,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp
);
   localparam int IdxW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int Half  = NUM_BINS / 2;
   localparam int FoldW = (Half > 1) ? $clog2(Half) : 1;
   localparam int QW    = 49;   // offset quotient width
   localparam int MQW   = 57;   // sum / count quotient width
   localparam int QcW   = 6;    // step counter width

   typedef enum logic [3:0] {
      S_IDLE, S_IDIV, S_ICHK, S_FRD, S_FWR, S_FCLR, S_URD, S_UWR, S_QRD, S_QCAP, S_MDIV,
      S_OUT
   } state_type;

   state_type       state_ff;
   cmd_type         c_ff;
   logic [SumW-1:0] sum_mem [NUM_BINS];
   logic [CntW-1:0] cnt_mem [NUM_BINS];
   logic [SumW-1:0] rsum_ff;
   logic [CntW-1:0] rcnt_ff;
   logic [IdxW-1:0] raddr;
   logic            rd_en;
   logic [WidW-1:0] width_ff;
   logic [QW-1:0]   iq_ff;
   logic [TsW:0]    irem_ff;
   logic [QcW-1:0]  step_ff;
   logic [IdxW-1:0] idx_ff;
   logic [FoldW-1:0] fi_ff;
   logic [IdxW-1:0] ci_ff;
   logic            fsecond_ff;
   logic            fold_ff;
   logic [SumW-1:0] fsum_ff;
   logic [CntW-1:0] fcnt_ff;
   logic [MQW-1:0]  mq_ff;
   logic [CntW:0]   mrem_ff;
   logic [SumW-1:0] osum_ff;
   logic [CntW-1:0] ocnt_ff;
   logic            ovalid_ff;
   rsp_type         rsp_ff;

   logic            wr_en;
   logic [IdxW-1:0] waddr;
   logic [SumW-1:0] wsum;
   logic [CntW-1:0] wcnt;

   logic [TsW+1:0]  itrial;
   logic [CntW+1:0] mtrial;
   logic [SumW:0]   fs_add, us_add;
   logic [CntW:0]   fc_add, uc_add;

   // restoring divider steps (offset by width, sum by count)
   assign itrial = {irem_ff, c_ff.offset[TsW-1 - step_ff]} - {1'b0, width_ff[TsW:0]};
   assign mtrial = {mrem_ff, osum_ff[SumW-1 - step_ff]} - {2'b00, ocnt_ff};

   assign fs_add = {1'b0, fsum_ff} + {1'b0, rsum_ff};
   assign fc_add = {1'b0, fcnt_ff} + {1'b0, rcnt_ff};
   assign us_add = {1'b0, rsum_ff} + {{(SumW-ValW+1){1'b0}}, c_ff.value};
   assign uc_add = {1'b0, rcnt_ff} + {{CntW{1'b0}}, 1'b1};

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp       = rsp_ff;

   // read address select
   always_comb begin
      raddr = idx_ff;
      rd_en = 1'b0;
      case (state_ff)
         S_FRD:   begin raddr = IdxW'({fi_ff, fsecond_ff}); rd_en = 1'b1; end
         S_URD:   begin raddr = idx_ff; rd_en = 1'b1; end
         S_QRD:   begin raddr = IdxW'(c_ff.qbin); rd_en = 1'b1; end
         default: begin raddr = idx_ff; rd_en = 1'b0; end
      endcase
   end

   // write port select
   always_comb begin
      wr_en = 1'b0;
      waddr = idx_ff;
      wsum  = '0;
      wcnt  = '0;
      case (state_ff)
         S_FWR: begin
            if (fsecond_ff) begin
               wr_en = 1'b1;
               waddr = IdxW'(fi_ff);
               wsum  = fs_add[SumW] ? '1 : fs_add[SumW-1:0];
               wcnt  = fc_add[CntW] ? '1 : fc_add[CntW-1:0];
            end
         end
         S_FCLR: begin
            wr_en = 1'b1;
            waddr = ci_ff;
         end
         S_UWR: begin
            wr_en = 1'b1;
            waddr = idx_ff;
            wsum  = us_add[SumW] ? '1 : us_add[SumW-1:0];
            wcnt  = uc_add[CntW] ? '1 : uc_add[CntW-1:0];
         end
         default: wr_en = 1'b0;
      endcase
   end

   // bin memories with a clearing pass after reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[waddr] <= wsum;
         cnt_mem[waddr] <= wcnt;
      end
      if (rd_en) begin
         rsum_ff <= sum_mem[raddr];
         rcnt_ff <= cnt_mem[raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_FCLR;
         ci_ff      <= '0;
         width_ff   <= WidW'(1);
         ovalid_ff  <= 1'b0;
         step_ff    <= '0;
         fi_ff      <= '0;
         fsecond_ff <= 1'b0;
         fold_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         if (ovalid_ff && rsp_ready && state_ff != S_OUT) ovalid_ff <= 1'b0;
         if (width_load)
            width_ff <= (width_value == '0) ? WidW'(1) : WidW'(width_value);
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  c_ff <= cmd;
                  if (cmd.op == OpQuery) begin
                     idx_ff <= IdxW'(cmd.qbin);
                     if ({27'd0, cmd.qbin} >= NUM_BINS) begin
                        osum_ff  <= '0;
                        ocnt_ff  <= '0;
                        state_ff <= S_OUT;
                     end else begin
                        state_ff <= S_QRD;
                     end
                  end else if (cmd.early) begin
                     osum_ff  <= '0;
                     ocnt_ff  <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     irem_ff  <= '0;
                     iq_ff    <= '0;
                     step_ff  <= '0;
                     state_ff <= S_IDIV;
                  end
               end
            end
            // one quotient bit per cycle of offset / width
            S_IDIV: begin
               if (!itrial[TsW+1]) begin
                  irem_ff <= itrial[TsW:0];
                  iq_ff   <= {iq_ff[QW-2:0], 1'b1};
               end else begin
                  irem_ff <= {irem_ff[TsW-1:0], c_ff.offset[TsW-1 - step_ff]};
                  iq_ff   <= {iq_ff[QW-2:0], 1'b0};
               end
               if (step_ff == QcW'(TsW-1)) state_ff <= S_ICHK;
               else step_ff <= step_ff + 1'b1;
            end
            S_ICHK: begin
               if (iq_ff >= QW'(NUM_BINS)) begin
                  fi_ff      <= '0;
                  fsecond_ff <= 1'b0;
                  fold_ff    <= 1'b1;
                  state_ff   <= S_FRD;
               end else begin
                  idx_ff   <= iq_ff[IdxW-1:0];
                  state_ff <= S_URD;
               end
            end
            // fold: read pair, combine, write low half
            S_FRD: state_ff <= S_FWR;
            S_FWR: begin
               if (!fsecond_ff) begin
                  fsum_ff    <= rsum_ff;
                  fcnt_ff    <= rcnt_ff;
                  fsecond_ff <= 1'b1;
                  state_ff   <= S_FRD;
               end else begin
                  fsecond_ff <= 1'b0;
                  if (fi_ff == FoldW'(Half-1)) begin
                     ci_ff    <= IdxW'(Half);
                     state_ff <= S_FCLR;
                  end else begin
                     fi_ff    <= fi_ff + 1'b1;
                     state_ff <= S_FRD;
                  end
               end
            end
            // clear the upper half after a fold (all bins after reset); after a fold double the width and re-check
            S_FCLR: begin
               if (ci_ff == IdxW'(NUM_BINS-1)) begin
                  if (fold_ff) begin
                     width_ff <= {width_ff[WidW-2:0], 1'b0};
                     iq_ff    <= {1'b0, iq_ff[QW-1:1]};
                     state_ff <= S_ICHK;
                  end else begin
                     state_ff <= S_IDLE;
                  end
                  fold_ff <= 1'b0;
                  fi_ff   <= '0;
               end else begin
                  ci_ff <= ci_ff + 1'b1;
               end
            end
            S_URD: state_ff <= S_UWR;
            S_UWR: begin
               osum_ff  <= wsum;
               ocnt_ff  <= wcnt;
               mrem_ff  <= '0;
               mq_ff    <= '0;
               step_ff  <= '0;
               state_ff <= S_MDIV;
            end
            S_QRD: state_ff <= S_QCAP;
            S_QCAP: begin
               osum_ff  <= rsum_ff;
               ocnt_ff  <= rcnt_ff;
               mrem_ff  <= '0;
               mq_ff    <= '0;
               step_ff  <= '0;
               state_ff <= S_MDIV;
            end
            // one quotient bit per cycle of sum / count
            S_MDIV: begin
               if (ocnt_ff == '0) begin
                  state_ff <= S_OUT;
               end else begin
                  if (!mtrial[CntW+1]) begin
                     mrem_ff <= mtrial[CntW:0];
                     mq_ff   <= {mq_ff[MQW-2:0], 1'b1};
                  end else begin
                     mrem_ff <= {mrem_ff[CntW-1:0], osum_ff[SumW-1 - step_ff]};
                     mq_ff   <= {mq_ff[MQW-2:0], 1'b0};
                  end
                  if (step_ff == QcW'(SumW-1)) state_ff <= S_OUT;
                  else step_ff <= step_ff + 1'b1;
               end
            end
            S_OUT: begin
               if (!ovalid_ff || rsp_ready) begin
                  ovalid_ff            <= 1'b1;
                  rsp_ff.status        <= c_ff.early ? StatEarly : StatOk;
                  rsp_ff.bin_index     <= c_ff.early ? '0 :
                                          (c_ff.op == OpQuery) ? c_ff.qbin : QbW'(idx_ff);
                  rsp_ff.bin_sum       <= osum_ff;
                  rsp_ff.bin_count     <= ocnt_ff;
                  rsp_ff.bin_mean      <= (ocnt_ff == '0) ? '0 :
                                          (mq_ff[MQW-2:CntW] != '0) ? '1 : mq_ff[CntW-1:0];
                  rsp_ff.current_width <= width_ff;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* design/folding_time_histogram.sv */
// folding_time_histogram: top level, csr registers and front/back wiring
// depends on fth_pkg, fth_req_if, fth_rsp_if, fth_front, fth_back
//
// channel | dir | handshake       | payload
// req     | in  | valid/ready     | op, timestamp, sample_value, query_bin
// rsp     | out | valid/ready     | status, bin_index, bin_sum, bin_count, bin_mean, width
// csr     | in  | apb, pready = 1 | start_time @0x0, initial_bin_width @0x8
//
// a sample passes through accept, bit-serial bin index division, index check, read, write,
// bit-serial mean division and the output step
// a query has no index division; an empty bin skips the mean division and an early sample skips both
// each fold sweeps the memory (pair reads and writes, then clearing the upper half) and re-checks the index
// after reset a clearing pass over all NUM_BINS bins runs before the back takes the first item
// a result held by a stalled receiver stops the back at its next output; the two-entry queue then fills
`default_nettype none
module folding_time_histogram import fth_pkg::*; #(
   parameter int NUM_BINS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   fth_req_if.sink               req,
   fth_rsp_if.source             rsp,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [CsrAw-1:0] csr_paddr,
   input  wire logic [CsrDw-1:0] csr_pwdata,
   output logic [CsrDw-1:0]      csr_prdata,
   output logic                  csr_pready
);
   logic [TsW-1:0] start_ff;
   logic [TsW-1:0] initw_ff;
   logic           wr;
   logic           cmd_valid, cmd_ready;
   cmd_type        cmd;
   rsp_type        r;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         initw_ff <= TsW'(1);
      end else if (wr) begin
         if (csr_paddr == RegStartTime) start_ff <= csr_pwdata[TsW-1:0];
         if (csr_paddr == RegInitWidth) initw_ff <= csr_pwdata[TsW-1:0];
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr)
         RegStartTime: csr_prdata = {{(CsrDw-TsW){1'b0}}, start_ff};
         RegInitWidth: csr_prdata = {{(CsrDw-TsW){1'b0}}, initw_ff};
         default:      csr_prdata = '0;
      endcase
   end

   fth_front u_front (
      .clock, .reset,
      .start_time   (start_ff),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .in_op        (req.op),
      .in_timestamp (req.timestamp),
      .in_value     (req.sample_value),
      .in_qbin      (req.query_bin),
      .cmd_valid, .cmd_ready, .cmd
   );

   fth_back #(.NUM_BINS(NUM_BINS)) u_back (
      .clock, .reset,
      .width_load  (wr && csr_paddr == RegInitWidth),
      .width_value (csr_pwdata[TsW-1:0]),
      .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp         (r)
   );

   assign rsp.status        = r.status;
   assign rsp.bin_index     = r.bin_index;
   assign rsp.bin_sum       = r.bin_sum;
   assign rsp.bin_count     = r.bin_count;
   assign rsp.bin_mean      = r.bin_mean;
   assign rsp.current_width = r.current_width;
endmodule
`default_nettype wire
